// ----- rtl/corner_point_suppression_table_macros.svh -----
// ----------------------------------------------------------------------------
// Corner point suppression table: assertion macros
// Shared concurrent assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef CORNER_POINT_SUPPRESSION_TABLE_MACROS_SVH
`define CORNER_POINT_SUPPRESSION_TABLE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define CPST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define CPST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cpst_pkg.sv -----
// ----------------------------------------------------------------------------
// Corner point suppression table package
// Field widths, payload structs, codes and control/status types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpst_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned COORD_BITS_DEF  = 12;

  localparam int unsigned CMD_W       = 2;
  localparam int unsigned POS_W       = 12;
  localparam int unsigned STR_W       = 8;
  localparam int unsigned SLOT_W      = 10;
  localparam int unsigned ACT_W       = 3;
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned DIAM_W      = 6;
  localparam int unsigned CFG_DATA_W  = 8;
  // Wide enough for any table index or count the parameter range allows
  localparam int unsigned EXT_W       = 17;
  // Wide enough for any coordinate the parameter range allows
  localparam int unsigned COORD_EXT_W = 16;

  localparam logic [STR_W-1:0]  MIN_RESPONSE_RST   = 8'd100;
  localparam logic [DIAM_W-1:0] POINT_DIAMETER_RST = 6'd6;

  typedef enum logic [CMD_W-1:0] {
    CMD_OFFER = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cpst_cmd_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_BELOW      = 3'd0,
    ACT_APPENDED   = 3'd1,
    ACT_REPLACED   = 3'd2,
    ACT_SUPPRESSED = 3'd3,
    ACT_FULL       = 3'd4,
    ACT_DONE       = 3'd5
  } cpst_act_e;

  typedef enum logic [0:0] {
    REG_MIN_RESPONSE   = 1'b0,
    REG_POINT_DIAMETER = 1'b1
  } cpst_cfg_reg_e;

  typedef enum logic [2:0] {
    FIN_BELOW    = 3'd0,
    FIN_REPLACE  = 3'd1,
    FIN_SCAN_END = 3'd2,
    FIN_READ     = 3'd3,
    FIN_CLEAR    = 3'd4,
    FIN_OTHER    = 3'd5
  } cpst_fin_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DECIDE = 2'd1,
    ST_SCAN   = 2'd2,
    ST_FINISH = 2'd3
  } cpst_state_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [STR_W-1:0]  strength;
    logic [SLOT_W-1:0] read_slot;
  } cpst_in_t;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] entry_count;
    logic [POS_W-1:0]   out_x;
    logic [POS_W-1:0]   out_y;
    logic [STR_W-1:0]   out_strength;
    logic               entry_valid;
  } cpst_out_t;

  typedef struct packed {
    logic      capture;
    logic      scan_start;
    logic      scan_issue;
    logic      read_issue;
    logic      load_out;
    cpst_fin_e fin_op;
  } cpst_ctrl_t;

  typedef struct packed {
    cpst_cmd_e cmd;
    logic      below;
    logic      count_zero;
    logic      issue_done;
    logic      hit_replace;
    logic      scan_last;
  } cpst_stat_t;

endpackage

// ----- rtl/cpst_datapath.sv -----
// ----------------------------------------------------------------------------
// Corner point suppression table datapath
// Point memory, entry count, settings, overlap compare and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpst_datapath import cpst_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cpst_in_t              in_data_i,
  input  logic                  cfg_we_i,
  input  cpst_cfg_reg_e         cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  cpst_ctrl_t            ctrl_i,
  output cpst_stat_t            stat_o,
  output cpst_out_t             out_data_o
);

  localparam int unsigned AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W   = AW + 1;
  localparam int unsigned CW      = COORD_BITS;
  localparam int unsigned ENTRY_W = 2 * CW + STR_W;

  logic [STR_W-1:0]   min_resp_q;
  logic [DIAM_W-1:0]  diam_q;
  cpst_cmd_e          cmd_q;
  logic [CW-1:0]      px_q, py_q;
  logic [STR_W-1:0]   str_q;
  logic [SLOT_W-1:0]  rslot_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   idx_q;
  logic [AW-1:0]      cidx_q;
  logic               rd_vld_q;
  logic               ovl_q;
  logic [ENTRY_W-1:0] rdata_q;
  cpst_out_t          out_q, out_d;

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

  logic [COORD_EXT_W-1:0] in_x_ext, in_y_ext;
  logic [CW-1:0]          rd_x, rd_y;
  logic [STR_W-1:0]       rd_s;
  logic [CW-1:0]          dx, dy;
  logic [COORD_EXT_W-1:0] dx_ext, dy_ext, ox_ext, oy_ext;
  logic                   far_x, far_y;
  logic [2*DIAM_W-1:0]    sq_x, sq_y, lim;
  logic [2*DIAM_W:0]      sq_sum;
  logic                   overlap;
  logic [EXT_W-1:0]       rslot_ext, cidx_ext, count_ext, cnt_out_ext;
  logic                   rslot_ok;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic                   rd_en, wr_en;

  // Settings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_resp_q <= MIN_RESPONSE_RST;
      diam_q     <= POINT_DIAMETER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MIN_RESPONSE:   min_resp_q <= cfg_data_i;
        REG_POINT_DIAMETER: diam_q     <= cfg_data_i[DIAM_W-1:0];
      endcase
    end
  end

  // Coordinates are taken modulo 2^COORD_BITS
  assign in_x_ext = COORD_EXT_W'(in_data_i.pos_x);
  assign in_y_ext = COORD_EXT_W'(in_data_i.pos_y);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q   <= cpst_cmd_e'(in_data_i.command);
      px_q    <= in_x_ext[CW-1:0];
      py_q    <= in_y_ext[CW-1:0];
      str_q   <= in_data_i.strength;
      rslot_q <= in_data_i.read_slot;
    end
  end

  // Overlap compare on the registered memory word
  assign rd_x = rdata_q[ENTRY_W-1 -: CW];
  assign rd_y = rdata_q[STR_W+CW-1 -: CW];
  assign rd_s = rdata_q[STR_W-1:0];

  assign dx     = (px_q >= rd_x) ? px_q - rd_x : rd_x - px_q;
  assign dy     = (py_q >= rd_y) ? py_q - rd_y : rd_y - py_q;
  assign dx_ext = COORD_EXT_W'(dx);
  assign dy_ext = COORD_EXT_W'(dy);
  // A difference of 64 or more squares above any diameter limit
  assign far_x  = |dx_ext[COORD_EXT_W-1:DIAM_W];
  assign far_y  = |dy_ext[COORD_EXT_W-1:DIAM_W];
  assign sq_x   = dx_ext[DIAM_W-1:0] * dx_ext[DIAM_W-1:0];
  assign sq_y   = dy_ext[DIAM_W-1:0] * dy_ext[DIAM_W-1:0];
  assign sq_sum = (2*DIAM_W+1)'(sq_x) + (2*DIAM_W+1)'(sq_y);
  assign lim    = diam_q * diam_q;
  assign overlap = !far_x && !far_y && (sq_sum < (2*DIAM_W+1)'(lim));

  assign cidx_ext  = EXT_W'(cidx_q);
  assign count_ext = EXT_W'(count_q);
  assign rslot_ext = EXT_W'(rslot_q);
  assign rslot_ok  = rslot_ext < count_ext;

  assign stat_o.cmd         = cmd_q;
  assign stat_o.below       = str_q <= min_resp_q;
  assign stat_o.count_zero  = count_q == '0;
  assign stat_o.issue_done  = idx_q == count_q;
  assign stat_o.hit_replace = rd_vld_q && overlap && (str_q > rd_s);
  assign stat_o.scan_last   = rd_vld_q && ((cidx_ext + EXT_W'(1)) == count_ext);

  // Scan address and compare tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      ovl_q    <= 1'b0;
      idx_q    <= '0;
    end else begin
      rd_vld_q <= ctrl_i.scan_issue;
      if (ctrl_i.capture) begin
        ovl_q <= 1'b0;
      end else if (rd_vld_q && overlap) begin
        ovl_q <= 1'b1;
      end
      if (ctrl_i.scan_start) begin
        idx_q <= '0;
      end else if (ctrl_i.scan_issue) begin
        idx_q <= idx_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.scan_issue) begin
      cidx_q <= idx_q[AW-1:0];
    end
  end

  assign rd_en   = ctrl_i.scan_issue || ctrl_i.read_issue;
  assign rd_addr = ctrl_i.read_issue ? rslot_ext[AW-1:0] : idx_q[AW-1:0];

  // Result of the finishing operation
  always_comb begin
    out_d        = '0;
    out_d.action = ACT_DONE;
    count_d      = count_q;
    wr_en        = 1'b0;
    wr_addr      = cidx_q;
    ox_ext       = COORD_EXT_W'(rd_x);
    oy_ext       = COORD_EXT_W'(rd_y);
    unique case (ctrl_i.fin_op)
      FIN_BELOW: begin
        out_d.action = ACT_BELOW;
      end
      FIN_REPLACE: begin
        out_d.action = ACT_REPLACED;
        out_d.slot   = cidx_ext[SLOT_W-1:0];
        wr_en        = 1'b1;
      end
      FIN_SCAN_END: begin
        priority if (ovl_q) begin
          out_d.action = ACT_SUPPRESSED;
        end else if (count_q >= CNT_W'(TABLE_DEPTH)) begin
          out_d.action = ACT_FULL;
        end else begin
          out_d.action = ACT_APPENDED;
          out_d.slot   = count_ext[SLOT_W-1:0];
          wr_en        = 1'b1;
          wr_addr      = count_q[AW-1:0];
          count_d      = count_q + CNT_W'(1);
        end
      end
      FIN_READ: begin
        out_d.slot = rslot_q;
        if (rslot_ok) begin
          out_d.entry_valid  = 1'b1;
          out_d.out_x        = ox_ext[POS_W-1:0];
          out_d.out_y        = oy_ext[POS_W-1:0];
          out_d.out_strength = rd_s;
        end
      end
      FIN_CLEAR: begin
        count_d = '0;
      end
      FIN_OTHER: begin
        out_d.action = ACT_DONE;
      end
    endcase
    cnt_out_ext       = EXT_W'(count_d);
    out_d.entry_count = cnt_out_ext[COUNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.load_out) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      out_q <= out_d;
    end
  end

  // Point memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out && wr_en) begin
      mem[wr_addr] <= {px_q, py_q, str_q};
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- rtl/cpst_ctrl.sv -----
// ----------------------------------------------------------------------------
// Corner point suppression table controller
// Sequences capture, table scan, read and result hand-off for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpst_ctrl import cpst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  cpst_stat_t stat_i,
  output cpst_ctrl_t ctrl_o
);

  cpst_state_e state_q, state_d;
  cpst_fin_e   fin_q, fin_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fin_q       <= FIN_OTHER;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    fin_d         = fin_q;
    ctrl_o        = '0;
    ctrl_o.fin_op = fin_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_FINISH;
        unique case (stat_i.cmd)
          CMD_OFFER: begin
            priority if (stat_i.below) begin
              fin_d = FIN_BELOW;
            end else begin
              ctrl_o.scan_start = 1'b1;
              fin_d             = FIN_SCAN_END;
              if (!stat_i.count_zero) begin
                state_d = ST_SCAN;
              end
            end
          end
          CMD_READ: begin
            ctrl_o.read_issue = 1'b1;
            fin_d             = FIN_READ;
          end
          CMD_CLEAR: fin_d = FIN_CLEAR;
          CMD_NOP:   fin_d = FIN_OTHER;
        endcase
      end
      ST_SCAN: begin
        // stop on the first replaceable overlap, drop any read in flight
        priority if (stat_i.hit_replace) begin
          fin_d   = FIN_REPLACE;
          state_d = ST_FINISH;
        end else if (stat_i.scan_last) begin
          fin_d   = FIN_SCAN_END;
          state_d = ST_FINISH;
        end else begin
          ctrl_o.scan_issue = !stat_i.issue_done;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          ctrl_o.load_out = 1'b1;
          state_d         = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/corner_point_suppression_table.sv -----
// Corner point suppression table
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one command per
// transaction: offer a corner candidate, read a table slot, or clear the table.
// Every command gives exactly one result transaction on out_valid_o /
// out_stall_i / out_data_o. Settings are written on cfg_valid_i / cfg_ready_o
// (always ready); the user must write them only while the block is idle, as the
// block itself does not enforce this. Below-threshold, read, clear and no-op
// commands pass from acceptance through the decide and finish states to the
// output register; an offered candidate also scans the stored points one per
// cycle through the registered memory read port, and stops at the first point
// that it replaces. One item is in work at a time; the next is accepted once
// the current result sits in the output register.
// Reset empties the table by zeroing the entry count; point memory is not
// cleared, and slots at or beyond the count are never reported.
// When the receiver stalls, the result holds in the output register; one
// further item may be accepted and worked on, and waits to finish until the
// output register is free.
// ----------------------------------------------------------------------------
// Corner point suppression table top level
// Non-maximum suppression of corner candidates into a bounded keypoint table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "corner_point_suppression_table_macros.svh"

module corner_point_suppression_table import cpst_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  cpst_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output cpst_out_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  cpst_cfg_reg_e         cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cpst_ctrl_t ctrl;
  cpst_stat_t stat;
  logic       cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  cpst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  cpst_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

  `CPST_ASSERT_IMP(a_load_into_free_slot, clk_i, rst_ni, ctrl.load_out, !(out_valid_o && out_stall_i), "result loaded over a stalled transaction")
  `CPST_ASSERT_IMP(a_scan_exclusive, clk_i, rst_ni, ctrl.scan_issue, !ctrl.load_out && !ctrl.read_issue && !ctrl.capture, "scan read overlaps another operation")
  `CPST_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o && !ctrl.load_out, "item accepted without entering work")

endmodule
